// ===== hw/rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: request opcodes, result
// status codes and the command that the control broadcasts to the cell row.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned OP_W   = 4;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_POP_BACK   = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_INSERT     = 4'd4,
    OP_READ       = 4'd5,
    OP_DELETE     = 4'd6,
    OP_REPLACE    = 4'd7,
    OP_CLEAR      = 4'd8
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What every cell does this cycle, relative to the selected slot.
  typedef enum logic [1:0] {
    CK_NONE  = 2'd0,  // hold
    CK_WRITE = 2'd1,  // selected slot loads the word
    CK_OPEN  = 2'd2,  // selected slot loads, slots above take from below
    CK_CLOSE = 2'd3   // selected slot and above take from above
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t               kind;
    logic signed [WORD_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/ils_cell.sv =====
// ----------------------------------------------------------------------------
// ils_cell
// One slot of the list: holds a word and moves it to or from its neighbors
// as the broadcast command says; drives its word on the read tap when hit.
// ----------------------------------------------------------------------------
module ils_cell #(
  parameter int unsigned DEPTH    = 64,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                                       clk,
  input  ils_pkg::cell_cmd_t                         cmd,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] sel_idx,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
  input  logic signed [ils_pkg::WORD_W-1:0]          from_lower,
  input  logic signed [ils_pkg::WORD_W-1:0]          from_upper,
  output logic signed [ils_pkg::WORD_W-1:0]          data_out,
  output logic        [ils_pkg::WORD_W-1:0]          tap_out
);
  import ils_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [WORD_W-1:0] data_r;
  logic signed [WORD_W-1:0] data_nxt;
  logic                     hit_sel;
  logic                     above_sel;

  assign hit_sel   = (sel_idx == MY_IDX);
  assign above_sel = (MY_IDX > sel_idx);

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.kind)
      CK_WRITE: begin
        if (hit_sel) data_nxt = cmd.value;
      end
      CK_OPEN: begin
        if (hit_sel) begin
          data_nxt = cmd.value;
        end else if (above_sel) begin
          data_nxt = from_lower;
        end
      end
      CK_CLOSE: begin
        if (hit_sel || above_sel) data_nxt = from_upper;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  assign tap_out  = (rd_idx == MY_IDX) ? data_r : '0;

endmodule

// ===== hw/rtl/indexed_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Ordered list of up to DEPTH signed words with 1-based positions: push and
// pop at both ends, insert, read, delete, replace and clear, built as a row
// of cells that shift in parallel.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  in_      | input     | in_valid/in_stall  | op, position, value
//  out_     | output    | out_valid/out_stall| status, read_value, length,
//           |           |                    | is_empty
//
//  The cell row shifts or loads at the edge that accepts a request, and the
//  result is loaded into the output register at that same edge.
//  One request per cycle is sustained while the result side takes results;
//  the output register and the AND-OR read tree over the cells set this.
//  in_stall rises only while a result waits and out_stall holds it.
//  Reset empties the list at once (count only; cell words are not cleared).
// ----------------------------------------------------------------------------
module indexed_list_store_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ils_pkg::OP_W-1:0]          in_op,
  input  logic [ils_pkg::POS_W-1:0]         in_position,
  input  logic signed [ils_pkg::WORD_W-1:0] in_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ils_pkg::STAT_W-1:0]        out_status,
  output logic signed [ils_pkg::WORD_W-1:0] out_read_value,
  output logic [ils_pkg::LEN_W-1:0]         out_length,
  output logic                              out_is_empty
);
  import ils_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // compare width wide enough for both the position and the count
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // control state
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // result payload register
  status_t                  status_r;
  logic signed [WORD_W-1:0] rdval_r;
  logic [LEN_W-1:0]         length_r;
  logic                     empty_r;

  // per-request decode
  logic             in_accept;
  logic             full;
  logic             empty;
  logic             pos_ok;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_m1;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_en;
  status_t          status;
  cell_cmd_t        cmd;
  cell_kind_t       kind;

  // cell row
  logic signed [WORD_W-1:0] cell_q   [DEPTH];
  logic        [WORD_W-1:0] cell_tap [DEPTH];
  logic        [WORD_W-1:0] tap_or;

  // Stall only while a finished result is held back.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign full    = (count_r >= FULL_CNT);
  assign empty   = (count_r == '0);
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_m1  = pos_ext - CMP_W'(1);
  assign pos_idx = IDX_W'(pos_m1);

  // Decode the request into a cell command, a read select and the new count.
  always_comb begin
    kind      = CK_NONE;
    sel_idx   = '0;
    rd_idx    = '0;
    rd_en     = 1'b0;
    status    = ST_DONE;
    count_nxt = count_r;
    unique case (op_t'(in_op))
      OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          kind      = CK_WRITE;
          sel_idx   = IDX_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          kind      = CK_OPEN;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_RANGE;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = IDX_W'(count_r - CNT_W'(1));
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_RANGE;
        end else begin
          rd_en     = 1'b1;
          kind      = CK_CLOSE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_INSERT: begin
        // a bad position wins over a full list
        if (!pos_ok) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          kind      = CK_OPEN;
          sel_idx   = pos_idx;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          rd_en  = 1'b1;
          rd_idx = pos_idx;
        end
      end
      OP_DELETE: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = pos_idx;
          kind      = CK_CLOSE;
          sel_idx   = pos_idx;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_REPLACE: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          kind    = CK_WRITE;
          sel_idx = pos_idx;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        // unused opcodes: drop, report done with no change
        status = ST_DONE;
      end
    endcase
  end

  // Touch the cells only on an accepted request.
  assign cmd.kind  = in_accept ? kind : CK_NONE;
  assign cmd.value = in_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] lower_w;
    logic signed [WORD_W-1:0] upper_w;
    if (i == 0) begin : g_bot
      // slot 0 never takes from below
      assign lower_w = in_value;
    end else begin : g_mid_lo
      assign lower_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      // top slot holds its word when the row closes
      assign upper_w = cell_q[i];
    end else begin : g_mid_hi
      assign upper_w = cell_q[i+1];
    end

    ils_cell #(
      .DEPTH    (DEPTH),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .sel_idx    (sel_idx),
      .rd_idx     (rd_idx),
      .from_lower (lower_w),
      .from_upper (upper_w),
      .data_out   (cell_q[i]),
      .tap_out    (cell_tap[i])
    );
  end

  // Only the selected cell drives its tap, so an OR collects the word.
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  assign out_valid_nxt = in_accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) count_r <= count_nxt;
    end
  end

  // Load a new result on accept; otherwise hold it.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r <= status;
      rdval_r  <= rd_en ? $signed(tap_or) : '0;
      length_r <= LEN_W'(count_nxt);
      empty_r  <= (count_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rdval_r;
  assign out_length     = length_r;
  assign out_is_empty   = empty_r;

endmodule

// ===== hw/rtl/ils_checker.sv =====
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks on the indexed list store: stall coupling, result
// consistency and the held result under stall.
// ----------------------------------------------------------------------------
module ils_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [ils_pkg::OP_W-1:0]          in_op,
  input logic [ils_pkg::POS_W-1:0]         in_position,
  input logic signed [ils_pkg::WORD_W-1:0] in_value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [ils_pkg::STAT_W-1:0]        out_status,
  input logic signed [ils_pkg::WORD_W-1:0] out_read_value,
  input logic [ils_pkg::LEN_W-1:0]         out_length,
  input logic                              out_is_empty
);
  import ils_pkg::*;

  // A held result stays put and stays valid.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_read_value) && $stable(out_length))
    else $error("result changed while stalled");

  // Requests are held back only by a waiting result.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled with no result waiting");

  // The empty flag agrees with the length.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_length == '0)))
    else $error("empty flag disagrees with length");

  // A failed request returns no word.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> (out_read_value == '0))
    else $error("error result carries a word");

  // A full error reports a full list.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_length == LEN_W'(DEPTH)))
    else $error("full status with list not full");

  // Inputs only watched for completeness of the port view.
  logic unused_in;
  assign unused_in = ^{in_valid, in_op, in_position, in_value};

endmodule

bind indexed_list_store_unit ils_checker #(
  .DEPTH (DEPTH)
) u_ils_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_op          (in_op),
  .in_position    (in_position),
  .in_value       (in_value),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_read_value (out_read_value),
  .out_length     (out_length),
  .out_is_empty   (out_is_empty)
);

// ===== dv/ils_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_list_checker
// Watches both channels of the indexed list store, runs every accepted
// request through its own list model and compares each accepted result with
// the oldest expected one. Hands the open and failed counts to the bench.
// ----------------------------------------------------------------------------
module ils_list_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [ils_pkg::OP_W-1:0]          in_op,
  input  logic [ils_pkg::POS_W-1:0]         in_position,
  input  logic signed [ils_pkg::WORD_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [ils_pkg::STAT_W-1:0]        out_status,
  input  logic signed [ils_pkg::WORD_W-1:0] out_read_value,
  input  logic [ils_pkg::LEN_W-1:0]         out_length,
  input  logic                              out_is_empty,
  output int                                pending,
  output int                                error_count
);
  import ils_pkg::*;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] word;
    logic [LEN_W-1:0]         len;
    logic                     empty;
  } list_result_t;

  logic signed [WORD_W-1:0] slots [DEPTH];
  int unsigned              held;
  list_result_t             results_due [$];
  int                       mismatches;

  // Apply one request to the model list and return the result it yields.
  function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [WORD_W-1:0] word);
    list_result_t r;
    bit           pos_ok;
    int unsigned  idx;
    bit           full;
    r.status = ST_DONE;
    r.word   = '0;
    pos_ok   = (pos >= 1) && (pos <= held);
    idx      = pos_ok ? pos - 1 : 0;
    full     = held >= DEPTH;
    case (op)
      OP_PUSH_BACK: begin
        if (full) r.status = ST_FULL;
        else begin
          slots[held] = word;
          held++;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) r.status = ST_FULL;
        else begin
          for (int k = held; k > 0; k--) slots[k] = slots[k-1];
          slots[0] = word;
          held++;
        end
      end
      OP_POP_BACK: begin
        if (held == 0) r.status = ST_RANGE;
        else begin
          r.word = slots[held-1];
          held--;
        end
      end
      OP_POP_FRONT: begin
        if (held == 0) r.status = ST_RANGE;
        else begin
          r.word = slots[0];
          for (int k = 0; k + 1 < held; k++) slots[k] = slots[k+1];
          held--;
        end
      end
      OP_INSERT: begin
        // bad position wins over a full list
        if (!pos_ok) r.status = ST_RANGE;
        else if (full) r.status = ST_FULL;
        else begin
          for (int k = held; k > idx; k--) slots[k] = slots[k-1];
          slots[idx] = word;
          held++;
        end
      end
      OP_READ: begin
        if (!pos_ok) r.status = ST_RANGE;
        else r.word = slots[idx];
      end
      OP_DELETE: begin
        if (!pos_ok) r.status = ST_RANGE;
        else begin
          r.word = slots[idx];
          for (int k = idx; k + 1 < held; k++) slots[k] = slots[k+1];
          held--;
        end
      end
      OP_REPLACE: begin
        if (!pos_ok) r.status = ST_RANGE;
        else slots[idx] = word;
      end
      OP_CLEAR: held = 0;
      default: ;
    endcase
    r.len   = LEN_W'(held);
    r.empty = (held == 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t want;
    if (!rst_n) begin
      results_due.delete();
      held = 0;
    end else begin
      // retire first: a result is always older than a request taken this edge
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result: status %0d word %h length %0d empty %0b",
                     $realtime, out_status, out_read_value, out_length, out_is_empty);
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status || out_read_value !== want.word ||
              out_length !== want.len || out_is_empty !== want.empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp/act status %0d/%0d word %h/%h length %0d/%0d empty %0b/%0b",
                       $realtime,
                       want.status, out_status, want.word, out_read_value,
                       want.len, out_length, want.empty, out_is_empty);
          end
        end
      end
      if (in_valid && !in_stall)
        results_due.push_back(apply_request(in_op, in_position, in_value));
    end
    pending     <= results_due.size();
    error_count <= mismatches;
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the indexed list store: a short directed run over the error and
// edge cases, then phases of random requests that fill, drain and stir the
// list, with random stalls on both sides and the checker keeping score.
// ----------------------------------------------------------------------------
module tb;
  import ils_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int          RANDOM_ITEMS = 650;
  localparam int          HOLD_AT      = 150;    // start of the long result-side hold
  localparam int          PAUSE_AT     = 350;    // sender waits for a full drain here
  localparam int          QUIET_AT     = 560;    // no idling from here on
  localparam int          LONG_HOLD    = 150;
  localparam int          DRAIN_LIMIT  = 2000;
  localparam int          CYCLE_LIMIT  = 200000;

  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIX, MODE_NOISE} phase_mode_t;

  logic                     clk;
  logic                     rst_n         = 1'b0;
  logic                     in_valid      = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_op         = '0;
  logic [POS_W-1:0]         in_position   = '0;
  logic signed [WORD_W-1:0] in_value      = '0;
  logic                     out_valid;
  logic                     out_stall     = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [WORD_W-1:0] out_read_value;
  logic [LEN_W-1:0]         out_length;
  logic                     out_is_empty;

  logic                     long_hold_req = 1'b0;
  logic                     quiet         = 1'b0;
  int                       pending;
  int                       errors;
  int                       cycle_count   = 0;
  int unsigned              est_len       = 0;   // list length, only to aim positions
  int                       random_sent   = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  indexed_list_store_unit #(.DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .out_is_empty   (out_is_empty)
  );

  ils_list_checker #(.DEPTH(DEPTH)) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_length     (out_length),
    .out_is_empty   (out_is_empty),
    .pending        (pending),
    .error_count    (errors)
  );

  // Track the list length so random positions mostly land inside the list.
  function automatic void note_length(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos);
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: if (est_len < DEPTH) est_len++;
      OP_POP_BACK, OP_POP_FRONT:   if (est_len > 0) est_len--;
      OP_INSERT: if (pos >= 1 && pos <= est_len && est_len < DEPTH) est_len++;
      OP_DELETE: if (pos >= 1 && pos <= est_len) est_len--;
      OP_CLEAR:  est_len = 0;
      default: ;
    endcase
  endfunction

  // Offer one request and hold it until the edge that takes it.
  task automatic offer(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                       input logic signed [WORD_W-1:0] word);
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= word;
    do @(posedge clk); while (in_stall);
    note_length(op, pos);
  endtask

  // Drop valid and let the given number of edges pass.
  task automatic rest(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a live position; now and then zero, one past the end, or anything.
  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return POS_W'(est_len + 1);
      2:       return POS_W'($urandom_range(0, 2**POS_W - 1));
      default: begin
        if (est_len > 0) return POS_W'($urandom_range(1, est_len));
        else return POS_W'($urandom_range(0, 2**POS_W - 1));
      end
    endcase
  endfunction

  // Build one request for the current phase.
  task automatic make_request(input phase_mode_t mode, output logic [OP_W-1:0] op,
                              output logic [POS_W-1:0] pos,
                              output logic signed [WORD_W-1:0] word);
    int r;
    int pick;
    r    = $urandom_range(0, 9);
    word = pick_word();
    pos  = pick_position();
    case (mode)
      MODE_GROW: begin
        if (est_len >= DEPTH) begin
          // full: every grow attempt must bounce, bad insert positions first
          if (r < 3) op = OP_PUSH_BACK;
          else if (r < 6) op = OP_PUSH_FRONT;
          else op = OP_INSERT;
        end else if (r < 4) begin
          op = OP_PUSH_BACK;
        end else if (r < 7 || est_len == 0) begin
          op = OP_PUSH_FRONT;
        end else begin
          op  = OP_INSERT;
          pos = POS_W'($urandom_range(1, est_len));
        end
      end
      MODE_SHRINK: begin
        if (r < 4) op = OP_POP_BACK;
        else if (r < 7) op = OP_POP_FRONT;
        else op = OP_DELETE;
      end
      MODE_MIX: begin
        // clear is rare so the list keeps some depth; the rest are near uniform, push-back a little rarer
        pick = $urandom_range(0, 39);
        if (pick == 0) op = OP_CLEAR;
        else op = OP_W'(pick % int'(OP_CLEAR));
      end
      default: begin
        if (r < 5) begin
          op = OP_W'($urandom_range(int'(OP_CLEAR) + 1, 2**OP_W - 1));
        end else begin
          op  = OP_W'($urandom_range(0, int'(OP_CLEAR)));
          pos = POS_W'($urandom_range(0, 2**POS_W - 1));
        end
      end
    endcase
  endtask

  // Result side: random stall bursts, one long hold on request, none when quiet.
  initial begin : result_side
    int burst;
    bit hold_seen;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_seen) begin
        hold_seen  = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 10);
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Kill the run if it hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    phase_mode_t              mode;
    int                       phase_left;
    int                       waited;
    bit                       hold_issued;
    bit                       pause_done;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
    hold_issued = 1'b0;
    pause_done  = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every request against an empty list must fail with a range error.
    offer(OP_POP_BACK,  '0, '0);
    offer(OP_POP_FRONT, '0, '0);
    offer(OP_READ,      7'd1, '0);
    offer(OP_INSERT,    7'd1, 32'sh1111_1111);  // insert cannot append
    offer(OP_DELETE,    '0, '0);
    offer(OP_REPLACE,   7'd1, 32'sh2222_2222);
    // Build a short list from the extreme words.
    offer(OP_PUSH_BACK,  '0, 32'sh7FFF_FFFF);
    offer(OP_PUSH_FRONT, '0, 32'sh8000_0000);
    offer(OP_PUSH_BACK,  '0, '1);
    offer(OP_INSERT,     7'd2, '0);
    offer(OP_INSERT,     7'd5, 32'sh3333_3333);  // one past the end
    offer(OP_READ,       '0, '0);
    offer(OP_READ,       '1, '0);                // every position bit set
    offer(OP_READ,       7'd4, '0);
    offer(OP_REPLACE,    7'd1, 32'sh1234_5678);
    offer(OP_READ,       7'd1, '0);
    offer(OP_DELETE,     7'd2, '0);
    offer(OP_DELETE,     7'd64, '0);
    offer(OP_POP_FRONT,  '0, '0);
    offer(OP_POP_BACK,   '0, '0);
    // Unused opcodes: no change, plain result.
    offer('1, 7'd1, 32'sh5555_5555);
    offer(OP_W'(int'(OP_CLEAR) + 1), '0, '0);
    offer(OP_PUSH_BACK,  '0, 32'sh5A5A_5A5A);
    offer(OP_CLEAR,      '0, '0);
    offer(OP_READ,       7'd1, '0);

    // Random phases; open with a fill so the full-list cases come early.
    mode       = MODE_GROW;
    phase_left = DEPTH - est_len + 4;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase_left <= 0) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: begin
            mode       = MODE_GROW;
            phase_left = DEPTH - est_len + $urandom_range(2, 5);
          end
          5, 6, 7, 8: begin
            mode       = MODE_SHRINK;
            phase_left = est_len + $urandom_range(2, 4);
          end
          19: begin
            mode       = MODE_NOISE;
            phase_left = $urandom_range(3, 8);
          end
          default: begin
            mode       = MODE_MIX;
            phase_left = $urandom_range(10, 40);
          end
        endcase
      end
      make_request(mode, op, pos, word);
      offer(op, pos, word);
      phase_left--;
      // ignored opcodes do not count toward the random total
      if (op <= OP_CLEAR) random_sent++;

      if (!hold_issued && random_sent >= HOLD_AT) begin
        // hold the result side a long stretch while requests keep coming
        hold_issued = 1'b1;
        long_hold_req <= 1'b1;
      end
      if (!quiet && random_sent >= QUIET_AT) quiet <= 1'b1;

      if (!pause_done && random_sent >= PAUSE_AT) begin
        // drain completely before going on
        pause_done = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end else if (random_sent < QUIET_AT && $urandom_range(0, 9) == 0) begin
        rest($urandom_range(1, 10));
      end
    end

    // Wait out every result, then a margin.
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (4) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ils_pkg.sv
hw/rtl/ils_cell.sv
hw/rtl/indexed_list_store_unit.sv
hw/rtl/ils_checker.sv
dv/ils_list_checker.sv
dv/tb.sv
